// ===== hdl/b64lw_pkg.sv =====
// b64lw_pkg: shared types, character codes and the base64 symbol lookup
// for the line-wrapped base64 encoder. No dependencies.
package b64lw_pkg;

    // Default line length in characters (CR LF not counted)
    localparam int LINE_CHARS_DEF = 76;

    // Character codes
    localparam logic [6:0] CH_CR  = 7'd13;
    localparam logic [6:0] CH_LF  = 7'd10;
    localparam logic [6:0] CH_PAD = 7'd61;

    // Work handed from the front to the back: four characters, an optional
    // CR LF after them, and whether the job ends the message.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic            line_break;
        logic            last;
    } job_t;

    // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] b64_sym(input logic [5:0] six);
        logic [6:0] v;
        v = {1'b0, six};
        if (six < 6'd26)
            b64_sym = v + 7'd65;
        else if (six < 6'd52)
            b64_sym = v + 7'd71;
        else if (six < 6'd62)
            b64_sym = v - 7'd4;
        else if (six == 6'd62)
            b64_sym = 7'd43;
        else
            b64_sym = 7'd47;
    endfunction

endpackage

// ===== hdl/b64lw_front.sv =====
// b64lw_front: accepts bytes, holds up to two pending bytes and the group
// count of the current line, and builds one job per full group or tail.
// Depends on b64lw_pkg.
module b64lw_front #(
    parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        data_byte,
    input  logic              end_of_message,
    input  logic              queue_full,
    output logic              job_push,
    output b64lw_pkg::job_t   job
);
    import b64lw_pkg::*;

    localparam int GROUPS   = LINE_CHARS / 4;
    localparam bit BREAK_ON = (LINE_CHARS % 4) == 0;
    localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS + 1) : 1;

    logic [15:0]   pend_reg, pend_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [GW-1:0] grp_reg, grp_next;

    logic          accept;
    logic [GW-1:0] grp_inc;
    logic          brk;
    logic [7:0]    b1, b2, t1, t2;
    logic          single;

    assign accept  = push && !queue_full;
    assign grp_inc = grp_reg + 1'b1;
    assign brk     = BREAK_ON && (grp_inc == GW'(GROUPS));

    // Byte roles: full group uses both pending bytes, tail uses what is left
    assign b1     = pend_reg[15:8];
    assign b2     = pend_reg[7:0];
    assign single = (cnt_reg == 2'd0);
    assign t1     = single ? data_byte : b1;
    assign t2     = single ? 8'h00 : data_byte;

    // Job build and state update
    always_comb
    begin
        pend_next        = pend_reg;
        cnt_next         = cnt_reg;
        grp_next         = grp_reg;
        job_push         = 1'b0;
        job.chars        = '0;
        job.line_break   = 1'b0;
        job.last         = end_of_message;
        if (cnt_reg == 2'd2)
        begin
            job.chars[0]   = b64_sym(b1[7:2]);
            job.chars[1]   = b64_sym({b1[1:0], b2[7:4]});
            job.chars[2]   = b64_sym({b2[3:0], data_byte[7:6]});
            job.chars[3]   = b64_sym(data_byte[5:0]);
            job.line_break = brk;
        end
        else
        begin
            job.chars[0]   = b64_sym(t1[7:2]);
            job.chars[1]   = b64_sym({t1[1:0], t2[7:4]});
            job.chars[2]   = single ? CH_PAD : b64_sym({t2[3:0], 2'b00});
            job.chars[3]   = CH_PAD;
        end
        if (accept)
        begin
            if (cnt_reg == 2'd2)
            begin
                job_push  = 1'b1;
                grp_next  = brk ? '0 : grp_inc;
                pend_next = '0;
                cnt_next  = 2'd0;
            end
            else if (cnt_reg == 2'd1)
            begin
                pend_next = {b1, data_byte};
                cnt_next  = 2'd2;
            end
            else
            begin
                pend_next = {data_byte, 8'h00};
                cnt_next  = 2'd1;
            end
            // End of message: flush the tail and start a fresh line
            if (end_of_message)
            begin
                job_push  = 1'b1;
                pend_next = '0;
                cnt_next  = 2'd0;
                grp_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= 2'd0;
            grp_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            grp_reg  <= grp_next;
        end
    end

endmodule

// ===== hdl/b64lw_job_fifo.sv =====
// b64lw_job_fifo: two-entry job queue between front and back, head always
// visible. Depends on b64lw_pkg.
module b64lw_job_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  b64lw_pkg::job_t   wr_job,
    input  logic              rd,
    output logic              full,
    output logic              head_valid,
    output b64lw_pkg::job_t   head
);
    import b64lw_pkg::*;

    job_t slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic v0_reg, v0_next, v1_reg, v1_next;

    assign full       = v1_reg;
    assign head_valid = v0_reg;
    assign head       = slot0_reg;

    // Shift on read, fill the lowest free slot on write
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        if (rd)
        begin
            slot0_next = slot1_reg;
            v0_next    = v1_reg;
            v1_next    = 1'b0;
        end
        if (wr)
        begin
            if (!v0_next)
            begin
                slot0_next = wr_job;
                v0_next    = 1'b1;
            end
            else
            begin
                slot1_next = wr_job;
                v1_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== hdl/b64lw_back.sv =====
// b64lw_back: moves the head job, one character per cycle unless stalled,
// into the output register, with CR LF and last mark; needs b64lw_pkg.
module b64lw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64lw_pkg::job_t   head,
    output logic              head_done,
    input  logic              pop,
    output logic              empty,
    output logic [6:0]        out_char,
    output logic              last_char
);
    import b64lw_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [6:0] ch_reg, ch_next;
    logic       lst_reg, lst_next;

    logic       advance;
    logic       final_ch;
    logic [6:0] sel;

    assign advance   = head_valid && (!ov_reg || pop);
    assign final_ch  = head.line_break ? (idx_reg == 3'd5) : (idx_reg == 3'd3);
    assign head_done = advance && final_ch;

    assign empty     = !ov_reg;
    assign out_char  = ch_reg;
    assign last_char = lst_reg;

    // Character select
    always_comb
    begin
        case (idx_reg)
            3'd0:    sel = head.chars[0];
            3'd1:    sel = head.chars[1];
            3'd2:    sel = head.chars[2];
            3'd3:    sel = head.chars[3];
            3'd4:    sel = CH_CR;
            3'd5:    sel = CH_LF;
            default: sel = CH_PAD;
        endcase
    end

    // Output register loads when a job is waiting and it is free or taken
    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        ch_next  = ch_reg;
        lst_next = lst_reg;
        if (advance)
        begin
            ch_next  = sel;
            lst_next = final_ch && head.last;
            ov_next  = 1'b1;
            idx_next = final_ch ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        lst_reg <= lst_next;
    end

endmodule

// ===== hdl/base64_line_wrapped_encoder.sv =====
// base64_line_wrapped_encoder: MIME-style base64 encoder with CR LF breaks.
// Depends on b64lw_pkg, b64lw_front, b64lw_job_fifo and b64lw_back.
//
// Input queue: present data_byte and end_of_message with push; a byte is
// taken on a clock edge with push high and full low. Output queue: out_char
// and last_char show the oldest character while empty is low; pop takes it.
// last_char marks the final character of each message (LF if the last full
// group closes a line).
// The first character of a group or tail passes through the job queue
// and then the output register once the byte that completes it is taken.
// Throughput: the front takes one byte per cycle while the job queue (two
// entries) has room. The back emits one character per cycle through its
// single output character register while the receiver keeps popping; a
// group gives it four characters to emit, six with CR LF.
// Reset clears pending bytes, the line position, the job queue and the
// output register's valid flag. When the receiver stalls, the current
// character holds, the job queue fills and full rises; nothing is dropped.
module base64_line_wrapped_encoder #(
    parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] out_char,
    output logic       last_char
);
    import b64lw_pkg::*;

    job_t new_job;
    job_t head_job;
    logic job_push;
    logic head_valid;
    logic head_done;

    b64lw_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .queue_full     (full),
        .job_push       (job_push),
        .job            (new_job)
    );

    b64lw_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (job_push),
        .wr_job     (new_job),
        .rd         (head_done),
        .full       (full),
        .head_valid (head_valid),
        .head       (head_job)
    );

    b64lw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_job),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

// ===== bench/base64_line_wrapped_encoder_tb.sv =====
// Self-checking bench for base64_line_wrapped_encoder: byte messages in,
// wrapped base64 characters out, checked against an in-bench encoder model.
// Depends on b64lw_pkg and the encoder RTL.

import b64lw_pkg::*;

// One expected output character
typedef struct packed {
    logic [6:0] ch;
    logic       last;
} enc_char_t;

// Tracks the encoder state and the characters still owed by the block
class b64_stream_model;
    logic [7:0]  held_first;
    logic [7:0]  held_second;
    int unsigned held_count;
    int unsigned groups_done;
    enc_char_t   expected_chars[$];
    int unsigned errors;
    int unsigned reported;

    function new();
        held_first  = 8'h00;
        held_second = 8'h00;
        held_count  = 0;
        groups_done = 0;
        errors      = 0;
        reported    = 0;
    endfunction

    // Standard alphabet, first symbol in the top byte
    function logic [6:0] symbol(input logic [5:0] six);
        logic [511:0] alphabet;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        return alphabet[8 * (63 - int'(six)) +: 7];
    endfunction

    // Accepted request: work out the characters it releases
    function void take_byte(input logic [7:0] b, input logic eom);
        enc_char_t burst[$];
        enc_char_t c;
        c.last = 1'b0;
        if (held_count == 2) begin
            c.ch = symbol(held_first[7:2]);
            burst.push_back(c);
            c.ch = symbol({held_first[1:0], held_second[7:4]});
            burst.push_back(c);
            c.ch = symbol({held_second[3:0], b[7:6]});
            burst.push_back(c);
            c.ch = symbol(b[5:0]);
            burst.push_back(c);
            groups_done = (groups_done + 1) % 64;
            // line full: CR LF, also when the message ends here
            if (groups_done * 4 == LINE_CHARS_DEF) begin
                c.ch = CH_CR;
                burst.push_back(c);
                c.ch = CH_LF;
                burst.push_back(c);
                groups_done = 0;
            end
            held_count = 0;
        end else if (held_count == 1) begin
            held_second = b;
            held_count  = 2;
        end else begin
            held_first = b;
            held_count = 1;
        end

        // tail of one or two bytes, padded, never followed by a line break
        if (eom) begin
            if (held_count == 1) begin
                c.ch = symbol(held_first[7:2]);
                burst.push_back(c);
                c.ch = symbol({held_first[1:0], 4'b0000});
                burst.push_back(c);
                c.ch = CH_PAD;
                burst.push_back(c);
                burst.push_back(c);
            end else if (held_count == 2) begin
                c.ch = symbol(held_first[7:2]);
                burst.push_back(c);
                c.ch = symbol({held_first[1:0], held_second[7:4]});
                burst.push_back(c);
                c.ch = symbol({held_second[3:0], 2'b00});
                burst.push_back(c);
                c.ch = CH_PAD;
                burst.push_back(c);
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            held_count  = 0;
            groups_done = 0;
        end

        foreach (burst[i])
            expected_chars.push_back(burst[i]);
    endfunction

    // Accepted result: compare with the oldest owed character
    function void match_char(input logic [6:0] ch, input logic last);
        enc_char_t want;
        if (expected_chars.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("ERROR: char %0d last %0d arrived with none expected", ch, last);
            end
            return;
        end
        want = expected_chars.pop_front();
        if (want.ch !== ch || want.last !== last) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("ERROR: expected char %0d last %0d, got char %0d last %0d",
                         want.ch, want.last, ch, last);
            end
        end
    endfunction
endclass

module base64_line_wrapped_encoder_tb;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned TARGET_ITEMS = 370;
    localparam int unsigned LINE_BYTES   = LINE_CHARS_DEF / 4 * 3;
    localparam int unsigned DIR_COUNT    = 15;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       end_of_message;
    logic       empty;
    logic       pop;
    logic [6:0] out_char;
    logic       last_char;

    b64_stream_model model;
    bit              steady;
    int unsigned     items_sent;
    int unsigned     idle_cycles;

    // Directed messages: one-byte tail, two-byte tail, bare group,
    // group plus one-byte tail, '+' and '/' symbols plus two-byte tail
    logic [7:0] dir_data [DIR_COUNT] = '{8'h4D,
                                         8'h00, 8'hFF,
                                         8'hFF, 8'hFF, 8'hFF,
                                         8'h00, 8'h00, 8'h00, 8'h80,
                                         8'hFB, 8'hFF, 8'hBF, 8'h01, 8'h7F};
    bit         dir_end  [DIR_COUNT] = '{1'b1,
                                         1'b0, 1'b1,
                                         1'b0, 1'b0, 1'b1,
                                         1'b0, 1'b0, 1'b0, 1'b1,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    base64_line_wrapped_encoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Byte values with extra weight on the extremes
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Present one request after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push           = 1'b1;
        data_byte      = b;
        end_of_message = eom;
        do @(posedge clk); while (full);
        model.take_byte(b, eom);
        items_sent++;
    endtask

    // Receiver: random stalls, checks each character taken
    initial
    begin
        int unsigned gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            repeat (gap)
            begin
                @(negedge clk);
                pop = 1'b0;
            end
            @(negedge clk);
            pop = 1'b1;
            do @(posedge clk); while (empty);
            model.match_char(out_char, last_char);
        end
    end

    // Watchdog on cycles with no request or result taken
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence: reset, directed messages, random messages, drain
    initial
    begin
        int unsigned kind;
        int unsigned msg_len;
        model          = new();
        steady         = 1'b0;
        items_sent     = 0;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = 8'h00;
        end_of_message = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_COUNT; i++)
            send_byte(dir_data[i], dir_end[i]);

        // random messages; some end exactly at a line break, some run past one
        while (items_sent < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
                msg_len = LINE_BYTES;
            else if (kind == 2)
                msg_len = $urandom_range(LINE_BYTES - 3, LINE_BYTES + 12);
            else
                msg_len = $urandom_range(1, 12);
            steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < msg_len; i++)
                send_byte(pick_byte(), i == msg_len - 1);
        end
        steady = 1'b0;
        @(negedge clk);
        push = 1'b0;

        // drain, then wait for anything stray
        while (model.expected_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (model.errors == 0 && model.expected_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/b64lw_pkg.sv
hdl/b64lw_front.sv
hdl/b64lw_job_fifo.sv
hdl/b64lw_back.sv
hdl/base64_line_wrapped_encoder.sv
bench/base64_line_wrapped_encoder_tb.sv
